// ----- rtl/bmrect_pkg.sv -----
// ----------------------------------------------------------------------------
// bmrect_pkg
// Shared types and constants for the bitmap rectangle set / clear / toggle
// block: field widths, operation codes, sequencer states and the divider
// result bundle.
// ----------------------------------------------------------------------------
package bmrect_pkg;

    // Fixed field widths
    localparam int COORD_W   = 10;   // one coordinate
    localparam int COUNT_W   = 21;   // running set-pixel count
    localparam int S_TDATA_W = 40;   // four packed coordinates
    localparam int M_TDATA_W = 24;   // count, padded to whole bytes
    localparam int GRP_BITS  = 8;    // pixels per popcount group

    // Operation codes carried in the slave-side tuser
    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_TOGGLE = 2'd2
    } t_req_op;

    // Command sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,   // sweep of the pixel memory after reset
        ST_IDLE,    // waiting for a command word
        ST_DIV,     // locating the first word of each row
        ST_WALK,    // one read issued per cycle over the rectangle
        ST_DRAIN,   // last writes and count updates settle
        ST_DONE     // result word handed to the output register
    } t_state;

    // Column divider result
    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] quot;
        logic [COORD_W-1:0] rem;
    } t_div_res;

endpackage

// ----- rtl/bmrect_coldiv.sv -----
// ----------------------------------------------------------------------------
// bmrect_coldiv
// Column splitter: reciprocal multiply that turns a column into its word
// index and its bit position within the word, registered in the cycle after
// start.
// ----------------------------------------------------------------------------
module bmrect_coldiv #(
    parameter int WORD_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [bmrect_pkg::COORD_W-1:0]  i_dividend,
    output bmrect_pkg::t_div_res            o_res
);

    localparam int DW    = bmrect_pkg::COORD_W;
    localparam int SH    = DW + $clog2(WORD_BITS);
    localparam int RCP_W = SH + 1;
    localparam int PRD_W = DW + RCP_W;
    // ceil(2**SH / WORD_BITS): exact quotient for every DW-bit column
    localparam logic [RCP_W-1:0] RECIP = RCP_W'((2 ** SH + WORD_BITS - 1) / WORD_BITS);

    logic             r_done;
    logic [DW-1:0]    r_quot;
    logic [DW-1:0]    r_rem;

    logic [PRD_W-1:0] prod;
    logic [DW-1:0]    quot;
    logic [DW-1:0]    rem;

    // Quotient by reciprocal, remainder by multiply back and subtract
    always_comb begin
        prod = PRD_W'(i_dividend) * PRD_W'(RECIP);
        quot = prod[SH +: DW];
        rem  = i_dividend - DW'(quot * DW'(WORD_BITS));
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= quot;
            r_rem  <= rem;
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem;

endmodule

// ----- rtl/bitmap_rectangle_set_clear_toggle.sv -----
// ----------------------------------------------------------------------------
// bitmap_rectangle_set_clear_toggle
// Square one-bit bitmap with rectangle set / clear / toggle commands and a
// running count of set pixels.
// ----------------------------------------------------------------------------
// A command word carries an operation and two inclusive corners; one result
// word follows with the set-pixel count after the command and a flag for
// corners out of order (such a command changes nothing). Pixels live in one
// memory of WORD_BITS-bit words, one row of the grid per group of words.
// After reset the block sweeps the whole memory to zero, one word a cycle,
// before it takes the first command. A command then runs from its acceptance
// until the block is ready again through these steps: the column divider
// splits the first column into word index and bit position, one memory read
// is issued per word per cycle and written back on the next cycle, the count
// pipeline drains into the running total, and the result word is handed to
// the output register once that register is free. An ignored command goes
// from its acceptance straight to handing over its result word.
// ----------------------------------------------------------------------------
module bitmap_rectangle_set_clear_toggle #(
    parameter int GRID_SIDE = 1024,
    parameter int WORD_BITS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command channel
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // left_col[9:0], top_row[19:10], right_col[29:20], bottom_row[39:30]
    input  logic [bmrect_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // req_type[1:0]
    input  logic [1:0]                        i_s_tuser,
    // result channel
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // lit_count[20:0], zero pad[23:21]
    output logic [bmrect_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // bad_rect[0]
    output logic                              o_m_tuser
);

    localparam int CW        = bmrect_pkg::COORD_W;
    localparam int NW        = bmrect_pkg::COUNT_W;
    localparam int ROW_WORDS = (GRID_SIDE + WORD_BITS - 1) / WORD_BITS;
    localparam int ROW_W     = $clog2(GRID_SIDE);
    localparam int WIDX_W    = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int ADDR_W    = ROW_W + WIDX_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int POP_W     = $clog2(WORD_BITS + 1);
    localparam int GB        = bmrect_pkg::GRP_BITS;
    localparam int NGRP      = (WORD_BITS + GB - 1) / GB;
    localparam int GCNT_W    = $clog2(GB + 1);
    localparam int LAST_IDX  = GRID_SIDE - 1;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    bmrect_pkg::t_state   r_state, n_state;
    bmrect_pkg::t_req_op  r_op;
    bmrect_pkg::t_div_res div_res;

    logic [ADDR_W-1:0]    r_clr_addr;
    logic [CW-1:0]        r_x1, r_x2, r_y2;
    logic                 r_bad;
    logic [CW-1:0]        r_row;
    logic [WIDX_W-1:0]    r_word, r_word_first;
    logic [CW-1:0]        r_base, r_base_first;
    logic [BIT_W-1:0]     r_rem_lo;
    logic                 r_first;

    logic [WORD_BITS-1:0] r_mem [MEM_DEPTH];
    logic [WORD_BITS-1:0] r_rd_data;

    logic                 r_p1_vld;
    logic [ADDR_W-1:0]    r_p1_addr;
    logic [WORD_BITS-1:0] r_p1_mask;
    logic                 r_p2_vld;
    logic [GCNT_W-1:0]    r_p2_gain [NGRP];
    logic [GCNT_W-1:0]    r_p2_loss [NGRP];
    logic                 r_p3_vld;
    logic [POP_W-1:0]     r_p3_gain, r_p3_loss;
    logic [NW-1:0]        r_total;

    logic                 r_out_vld;
    logic [NW-1:0]        r_out_count;
    logic                 r_out_bad;

    // command fields
    logic [1:0]           in_op;
    logic [CW-1:0]        in_x1, in_y1, in_x2, in_y2;
    logic [CW-1:0]        in_x2c, in_y2c;
    logic                 in_bad, in_op_ok, in_on_grid, cmd_go;

    // sequencer strobes
    logic                 acc, div_start, walk_en, clr_en, out_load;

    // walk datapath
    logic [CW-1:0]        col_diff;
    logic                 last_word, last_row;
    logic [BIT_W-1:0]     lo, hi;
    logic [WORD_BITS-1:0] walk_mask;
    logic [ADDR_W-1:0]    walk_addr;

    // modify datapath
    logic [WORD_BITS-1:0] new_word, gain_bits, loss_bits;
    logic [GCNT_W-1:0]    grp_gain [NGRP];
    logic [GCNT_W-1:0]    grp_loss [NGRP];
    logic [POP_W-1:0]     sum_gain, sum_loss;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    // ------------------------------------------------------------------
    // Command decode and clipping
    // ------------------------------------------------------------------
    always_comb begin
        in_op      = i_s_tuser;
        in_x1      = i_s_tdata[CW-1:0];
        in_y1      = i_s_tdata[2*CW-1:CW];
        in_x2      = i_s_tdata[3*CW-1:2*CW];
        in_y2      = i_s_tdata[4*CW-1:3*CW];
        in_bad     = (in_x1 > in_x2) || (in_y1 > in_y2);
        in_op_ok   = (in_op == bmrect_pkg::OP_SET) || (in_op == bmrect_pkg::OP_CLEAR)
                     || (in_op == bmrect_pkg::OP_TOGGLE);
        in_on_grid = (32'(in_x1) < GRID_SIDE) && (32'(in_y1) < GRID_SIDE);
        cmd_go     = !in_bad && in_op_ok && in_on_grid;
        in_x2c     = (32'(in_x2) > LAST_IDX) ? CW'(LAST_IDX) : in_x2;
        in_y2c     = (32'(in_y2) > LAST_IDX) ? CW'(LAST_IDX) : in_y2;
    end

    // ------------------------------------------------------------------
    // Column divider: first word of each row and first bit in it
    // ------------------------------------------------------------------
    bmrect_coldiv #(
        .WORD_BITS (WORD_BITS)
    ) u_coldiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (in_x1),
        .o_res      (div_res)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmrect_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        acc       = 1'b0;
        div_start = 1'b0;
        walk_en   = 1'b0;
        clr_en    = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            bmrect_pkg::ST_CLEAR: begin
                clr_en = 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = bmrect_pkg::ST_IDLE;
                end
            end
            bmrect_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    acc = 1'b1;
                    if (cmd_go) begin
                        div_start = 1'b1;
                        n_state   = bmrect_pkg::ST_DIV;
                    end else begin
                        n_state = bmrect_pkg::ST_DONE;
                    end
                end
            end
            bmrect_pkg::ST_DIV: begin
                if (div_res.done) begin
                    n_state = bmrect_pkg::ST_WALK;
                end
            end
            bmrect_pkg::ST_WALK: begin
                walk_en = 1'b1;
                if (last_word && last_row) begin
                    n_state = bmrect_pkg::ST_DRAIN;
                end
            end
            bmrect_pkg::ST_DRAIN: begin
                if (!r_p1_vld && !r_p2_vld && !r_p3_vld) begin
                    n_state = bmrect_pkg::ST_DONE;
                end
            end
            bmrect_pkg::ST_DONE: begin
                if (!r_out_vld || i_m_tready) begin
                    out_load = 1'b1;
                    n_state  = bmrect_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bmrect_pkg::ST_CLEAR;
            end
        endcase
    end

    assign o_s_tready = (r_state == bmrect_pkg::ST_IDLE);

    // clearing sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (clr_en) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Rectangle walk: one word per cycle, row by row
    // ------------------------------------------------------------------
    always_comb begin
        col_diff  = r_x2 - r_base;
        last_word = (col_diff < CW'(WORD_BITS));
        last_row  = (r_row == r_y2);
        lo        = r_first ? r_rem_lo : '0;
        hi        = last_word ? col_diff[BIT_W-1:0] : BIT_W'(WORD_BITS - 1);
        for (int i = 0; i < WORD_BITS; i++) begin
            walk_mask[i] = (BIT_W'(i) >= lo) && (BIT_W'(i) <= hi);
        end
        walk_addr = {ROW_W'(r_row), r_word};
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op  <= bmrect_pkg::t_req_op'(in_op);
            r_x1  <= in_x1;
            r_x2  <= in_x2c;
            r_y2  <= in_y2c;
            r_row <= in_y1;
            r_bad <= in_bad;
        end
        if (div_res.done) begin
            r_word       <= WIDX_W'(div_res.quot);
            r_word_first <= WIDX_W'(div_res.quot);
            r_rem_lo     <= BIT_W'(div_res.rem);
            r_base       <= r_x1 - div_res.rem;
            r_base_first <= r_x1 - div_res.rem;
            r_first      <= 1'b1;
        end else if (walk_en) begin
            if (last_word) begin
                r_row   <= r_row + CW'(1);
                r_word  <= r_word_first;
                r_base  <= r_base_first;
                r_first <= 1'b1;
            end else begin
                r_word  <= r_word + WIDX_W'(1);
                r_base  <= r_base + CW'(WORD_BITS);
                r_first <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_comb begin
        mem_we    = clr_en || r_p1_vld;
        mem_waddr = clr_en ? r_clr_addr : r_p1_addr;
        mem_wdata = clr_en ? '0 : new_word;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[walk_addr];
    end

    // ------------------------------------------------------------------
    // Modify stage: new word and per-group changed-pixel counts
    // ------------------------------------------------------------------
    always_comb begin
        gain_bits = ~r_rd_data & r_p1_mask;
        loss_bits = r_rd_data & r_p1_mask;
        case (r_op)
            bmrect_pkg::OP_SET: begin
                new_word  = r_rd_data | r_p1_mask;
                loss_bits = '0;
            end
            bmrect_pkg::OP_CLEAR: begin
                new_word  = r_rd_data & ~r_p1_mask;
                gain_bits = '0;
            end
            bmrect_pkg::OP_TOGGLE: begin
                new_word = r_rd_data ^ r_p1_mask;
            end
            default: begin
                new_word  = r_rd_data;
                gain_bits = '0;
                loss_bits = '0;
            end
        endcase
        for (int g = 0; g < NGRP; g++) begin
            grp_gain[g] = '0;
            grp_loss[g] = '0;
            for (int b = 0; b < GB; b++) begin
                if (g * GB + b < WORD_BITS) begin
                    grp_gain[g] = grp_gain[g] + GCNT_W'(gain_bits[g * GB + b]);
                    grp_loss[g] = grp_loss[g] + GCNT_W'(loss_bits[g * GB + b]);
                end
            end
        end
    end

    // group sums
    always_comb begin
        sum_gain = '0;
        sum_loss = '0;
        for (int g = 0; g < NGRP; g++) begin
            sum_gain = sum_gain + POP_W'(r_p2_gain[g]);
            sum_loss = sum_loss + POP_W'(r_p2_loss[g]);
        end
    end

    // pipeline valids and running total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_total  <= '0;
        end else begin
            r_p1_vld <= walk_en;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
            if (r_p3_vld) begin
                r_total <= r_total + NW'(r_p3_gain) - NW'(r_p3_loss);
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_p1_addr <= walk_addr;
        r_p1_mask <= walk_mask;
        r_p2_gain <= grp_gain;
        r_p2_loss <= grp_loss;
        r_p3_gain <= sum_gain;
        r_p3_loss <= sum_loss;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_count <= r_total;
            r_out_bad   <= r_bad;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {(bmrect_pkg::M_TDATA_W - NW)'(0), r_out_count};
    assign o_m_tuser  = r_out_bad;

endmodule

// ----- rtl/bmrect_check.sv -----
// ----------------------------------------------------------------------------
// bmrect_check
// Port-level checks for the bitmap rectangle block, bound to the top level.
// ----------------------------------------------------------------------------
module bmrect_check (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [bmrect_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input logic                              o_m_tuser
);

    // reset starts the clearing sweep: nothing offered, nothing taken
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("outputs active straight after reset");

    // one command at a time: ready drops after a command word is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("command taken while another is in progress");

    // a fresh result only appears while the command side is busy
    a_result_from_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result word appeared without a command in progress");

    // result word holds while stalled
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result word changed");

endmodule

bind bitmap_rectangle_set_clear_toggle bmrect_check u_bmrect_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the bitmap rectangle set / clear / toggle block. Commands go
// in on the slave stream, and a bit-exact copy of the bitmap and its set-pixel
// count is updated for each command word accepted. Every result word is then
// checked against the oldest pending prediction. The run covers directed
// corner cases, random rectangles, a long output stall and a final stretch
// with no idling on either side.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int GRID_SIDE    = 1024;
    localparam int WORD_BITS    = 64;
    localparam int QUIET_LIMIT  = 100000;  // > clear sweep or full-grid command, several times
    localparam int LONG_HOLD    = 400;     // output stall for the back-pressure test
    localparam int DRAIN_CYCLES = 64;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef logic [bmrect_pkg::COORD_W-1:0] t_coord;

    typedef struct {
        logic [bmrect_pkg::COUNT_W-1:0] lit_count;
        logic                           bad_rect;
    } t_rect_result;

    // clock and reset
    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // DUT connections
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [bmrect_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [1:0]                       s_tuser  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [bmrect_pkg::M_TDATA_W-1:0] m_tdata;
    logic                             m_tuser;

    bitmap_rectangle_set_clear_toggle #(
        .GRID_SIDE (GRID_SIDE),
        .WORD_BITS (WORD_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    // shadow bitmap and count
    bit [GRID_SIDE-1:0] shadow_rows [GRID_SIDE];
    int unsigned        shadow_total = 0;

    t_rect_result pending_results [$];
    int           err_cnt       = 0;
    bit           idle_on       = 1'b1;
    bit           long_hold_req = 1'b0;
    int           stall_left    = 0;
    int           quiet_cycles  = 0;

    // Apply one command to the shadow bitmap and return the result it gives
    function automatic t_rect_result apply_rect_cmd(input logic [1:0] op,
                                                    input t_coord x1, y1, x2, y2);
        t_rect_result       res;
        bit [GRID_SIDE-1:0] ones;
        bit [GRID_SIDE-1:0] span;
        bit [GRID_SIDE-1:0] old_row;
        bit [GRID_SIDE-1:0] new_row;
        int unsigned        x_end;
        int unsigned        y_end;
        int unsigned        r;
        ones = '1;
        res.bad_rect = (x1 > x2) || (y1 > y2);
        // order check on raw corners; clipping only after it
        if (!res.bad_rect && op != OP_UNUSED && x1 < GRID_SIDE && y1 < GRID_SIDE) begin
            x_end = (x2 >= GRID_SIDE) ? GRID_SIDE - 1 : x2;
            y_end = (y2 >= GRID_SIDE) ? GRID_SIDE - 1 : y2;
            span  = (ones >> (GRID_SIDE - 1 - x_end)) & (ones << x1);
            for (r = y1; r <= y_end; r++) begin
                old_row = shadow_rows[r];
                case (op)
                    bmrect_pkg::OP_SET:   new_row = old_row | span;
                    bmrect_pkg::OP_CLEAR: new_row = old_row & ~span;
                    default:              new_row = old_row ^ span;
                endcase
                shadow_total = shadow_total - $countones(old_row & span)
                               + $countones(new_row & span);
                shadow_rows[r] = new_row;
            end
        end
        res.lit_count = shadow_total[bmrect_pkg::COUNT_W-1:0];
        return res;
    endfunction

    // Offer one command word, wait for it to be taken, then log the prediction
    task automatic send_rect_cmd(input logic [1:0] op, input t_coord x1, y1, x2, y2);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y2, x2, y1, x1};
        s_tuser  <= op;
        do @(posedge i_clk); while (!s_tready);
        pending_results.push_back(apply_rect_cmd(op, x1, y1, x2, y2));
    endtask

    // Random command: mostly small rectangles, some large, a few full-grid and bad
    task automatic send_random_cmd(input bit small_only);
        logic [1:0]  op;
        int unsigned pick;
        int unsigned x1, y1, x2, y2;
        pick = small_only ? 99 : $urandom_range(0, 99);
        case ($urandom_range(0, 2))
            0:       op = bmrect_pkg::OP_SET;
            1:       op = bmrect_pkg::OP_CLEAR;
            default: op = bmrect_pkg::OP_TOGGLE;
        endcase
        if ($urandom_range(0, 19) == 0)
            op = OP_UNUSED;
        x1 = $urandom_range(0, GRID_SIDE - 1);
        y1 = $urandom_range(0, GRID_SIDE - 1);
        if (pick < 2) begin
            x1 = 0;
            y1 = 0;
            x2 = GRID_SIDE - 1;
            y2 = GRID_SIDE - 1;
        end else if (pick < 10) begin
            // corners out of order on one axis, the other axis anything
            x2 = $urandom_range(0, GRID_SIDE - 1);
            y2 = $urandom_range(0, GRID_SIDE - 1);
            if ($urandom_range(0, 1) == 0) begin
                x1 = $urandom_range(1, GRID_SIDE - 1);
                x2 = $urandom_range(0, x1 - 1);
            end else begin
                y1 = $urandom_range(1, GRID_SIDE - 1);
                y2 = $urandom_range(0, y1 - 1);
            end
        end else if (pick < 20) begin
            x2 = $urandom_range(x1, GRID_SIDE - 1);
            y2 = $urandom_range(y1, GRID_SIDE - 1);
        end else begin
            x2 = x1 + $urandom_range(0, 160);
            y2 = y1 + $urandom_range(0, 24);
            if (x2 > GRID_SIDE - 1) x2 = GRID_SIDE - 1;
            if (y2 > GRID_SIDE - 1) y2 = GRID_SIDE - 1;
        end
        send_rect_cmd(op, t_coord'(x1), t_coord'(y1), t_coord'(x2), t_coord'(y2));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Corner cases: single pixels, word boundaries, full grid, bad corners, unused op
    task automatic test_directed_ops();
        send_rect_cmd(bmrect_pkg::OP_SET,    10'd0,    10'd0,    10'd0,    10'd0);
        send_rect_cmd(bmrect_pkg::OP_SET,    10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send_rect_cmd(bmrect_pkg::OP_TOGGLE, 10'd60,   10'd5,    10'd70,   10'd5);
        send_rect_cmd(bmrect_pkg::OP_CLEAR,  10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send_rect_cmd(bmrect_pkg::OP_SET,    10'd0,    10'd0,    10'd1023, 10'd1023);
        send_rect_cmd(OP_UNUSED,             10'd0,    10'd0,    10'd1023, 10'd1023);
        send_rect_cmd(bmrect_pkg::OP_TOGGLE, 10'd64,   10'd10,   10'd127,  10'd20);
        send_rect_cmd(bmrect_pkg::OP_CLEAR,  10'd0,    10'd0,    10'd1023, 10'd0);
        send_rect_cmd(bmrect_pkg::OP_SET,    10'd5,    10'd0,    10'd4,    10'd0);
        send_rect_cmd(bmrect_pkg::OP_TOGGLE, 10'd0,    10'd9,    10'd10,   10'd8);
        send_rect_cmd(bmrect_pkg::OP_CLEAR,  10'd1023, 10'd1023, 10'd0,    10'd0);
        send_rect_cmd(OP_UNUSED,             10'd3,    10'd3,    10'd2,    10'd2);
        send_rect_cmd(bmrect_pkg::OP_TOGGLE, 10'd0,    10'd0,    10'd1023, 10'd1023);
        send_rect_cmd(bmrect_pkg::OP_SET,    10'd1023, 10'd0,    10'd1023, 10'd1023);
        send_rect_cmd(bmrect_pkg::OP_SET,    10'd0,    10'd1023, 10'd1023, 10'd1023);
        send_rect_cmd(OP_UNUSED,             10'd100,  10'd100,  10'd300,  10'd110);
        send_rect_cmd(bmrect_pkg::OP_TOGGLE, 10'd63,   10'd500,  10'd64,   10'd520);
        send_rect_cmd(bmrect_pkg::OP_CLEAR,  10'd0,    10'd0,    10'd1023, 10'd1023);
        wait_drained();
    endtask

    task automatic test_random_rects();
        repeat (56) send_random_cmd(1'b0);
        wait_drained();
    endtask

    // Hold the output off for a long stretch while commands keep coming
    task automatic test_output_stall();
        long_hold_req = 1'b1;
        repeat (8) send_random_cmd(1'b1);
        wait_drained();
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (20) send_random_cmd(1'b0);
        wait_drained();
    endtask

    // result side ready: random stalls plus the one long hold
    always @(posedge i_clk) begin
        if (stall_left == 0 && long_hold_req) begin
            stall_left    = LONG_HOLD;
            long_hold_req = 1'b0;
        end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 17);
        end
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result check against the oldest pending word
    always @(posedge i_clk) begin
        t_rect_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with none pending: lit_count %0d bad_rect %0b",
                       m_tdata[bmrect_pkg::COUNT_W-1:0], m_tuser);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[bmrect_pkg::COUNT_W-1:0] !== want.lit_count) begin
                    $error("lit_count: expected %0d, got %0d",
                           want.lit_count, m_tdata[bmrect_pkg::COUNT_W-1:0]);
                    err_cnt++;
                end
                if (m_tuser !== want.bad_rect) begin
                    $error("bad_rect: expected %0b, got %0b", want.bad_rect, m_tuser);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no word moved on either side
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL bitmap_rectangle_set_clear_toggle");
            $finish;
        end
    end

    // test sequence
    initial begin
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        test_directed_ops();
        test_random_rects();
        test_output_stall();
        test_back_to_back();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("PASS bitmap_rectangle_set_clear_toggle");
        end else begin
            $display("FAIL bitmap_rectangle_set_clear_toggle");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/bmrect_pkg.sv
rtl/bmrect_coldiv.sv
rtl/bitmap_rectangle_set_clear_toggle.sv
rtl/bmrect_check.sv
tb/tb_top.sv
